>>> design/gdc_pkg.sv
// Shared types, control codes, calendar helpers and the microcode program
// for the Gregorian date counter. No dependencies.
package gdc_pkg;

  // Request kinds
  localparam logic [1:0] K_SET  = 2'd0;
  localparam logic [1:0] K_FWD  = 2'd1;
  localparam logic [1:0] K_BWD  = 2'd2;
  localparam logic [1:0] K_DIST = 2'd3;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [13:0] YEAR_RST = 14'd2000;

  // Datapath operations, one per control word
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_CHECK     = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd2;
  localparam logic [OP_W-1:0] OP_STEP      = 4'd3;
  localparam logic [OP_W-1:0] OP_SER_HELD  = 4'd4;
  localparam logic [OP_W-1:0] OP_SER_GIVEN = 4'd5;
  localparam logic [OP_W-1:0] OP_SAVE_A    = 4'd6;
  localparam logic [OP_W-1:0] OP_DIST      = 4'd7;
  localparam logic [OP_W-1:0] OP_CAPT      = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT      = 4'd9;

  // Sequencing conditions
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] C_NEXT    = 3'd0;
  localparam logic [CND_W-1:0] C_JUMP    = 3'd1;
  localparam logic [CND_W-1:0] C_IF_SET  = 3'd2;
  localparam logic [CND_W-1:0] C_IF_DIST = 3'd3;
  localparam logic [CND_W-1:0] C_WHILE   = 3'd4;
  localparam logic [CND_W-1:0] C_END     = 3'd5;

  localparam int PC_W = 5;

  // Program entry points
  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_STEP  = 5'd2;
  localparam logic [PC_W-1:0] PC_TAIL  = 5'd3;
  localparam logic [PC_W-1:0] PC_EMIT  = 5'd7;
  localparam logic [PC_W-1:0] PC_SET   = 5'd10;
  localparam logic [PC_W-1:0] PC_DIST  = 5'd12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [15:0] step_count;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [21:0] serial_day;
    logic        set_ok;
    logic [21:0] distance;
  } out_res_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Sequencer inputs from the datapath and output side
  typedef struct packed {
    logic kind_set;
    logic kind_dist;
    logic step_done;
    logic out_free;
  } seq_stat_t;

  // Sequencer outputs
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            emit;
    logic            busy;
  } seq_ctrl_t;

  // Microcode program. The NOP steps between a serial launch and its read wait for the serial pipeline.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = '{OP_CHECK,     C_IF_SET,  PC_SET};
      5'd1:    w = '{OP_NOP,       C_IF_DIST, PC_DIST};
      5'd2:    w = '{OP_STEP,      C_WHILE,   PC_STEP};
      5'd3:    w = '{OP_SER_HELD,  C_NEXT,    PC_START};
      5'd4:    w = '{OP_NOP,       C_NEXT,    PC_START};
      5'd5:    w = '{OP_NOP,       C_NEXT,    PC_START};
      5'd6:    w = '{OP_CAPT,      C_NEXT,    PC_START};
      5'd7:    w = '{OP_EMIT,      C_END,     PC_START};
      5'd10:   w = '{OP_LOAD,      C_JUMP,    PC_TAIL};
      5'd12:   w = '{OP_SER_GIVEN, C_NEXT,    PC_START};
      5'd13:   w = '{OP_SER_HELD,  C_NEXT,    PC_START};
      5'd14:   w = '{OP_NOP,       C_NEXT,    PC_START};
      5'd15:   w = '{OP_SAVE_A,    C_NEXT,    PC_START};
      5'd16:   w = '{OP_DIST,      C_JUMP,    PC_EMIT};
      default: w = '{OP_NOP,       C_JUMP,    PC_EMIT};
    endcase
    return w;
  endfunction

  // Leap year: y/100 by reciprocal multiply, exact below 43699
  function automatic logic leap_of(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] r;
    prod = {13'd0, y} * 27'd5243;
    q    = prod[26:19];
    r    = y - 14'({6'd0, q} * 14'd100);
    return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m, clamped past December
  function automatic logic [8:0] before_month(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      default:    v = 9'd334;
    endcase
    return v;
  endfunction

  function automatic logic date_valid(input logic [4:0] d, input logic [3:0] m,
                                      input logic [13:0] y);
    logic [4:0] len;
    len = month_len(m, leap_of(y));
    return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) &&
           (d >= 5'd1) && (d <= len);
  endfunction

endpackage

>>> design/gregorian_date_counter_unit.sv
// Gregorian date counter top level: request capture, output register and
// the sequencer and datapath. Depends on gdc_pkg, gdc_sequencer, gdc_datapath.
//
// Usage: a request on in_req (valid/stall) sets the held date, steps it
// forward or backward by step_count days, or measures the day distance to a
// given date. Each request gives one result on out_res (valid/stall) with
// the held date, its serial day number, the set flag and the distance.
// One request is worked at a time; in_stall is high while it runs.
// Flow in microcode steps: set checks the date and loads it if valid; step
// moves the held date one day per cycle in the stepping loop until step_count
// days are moved or the end of the date range is reached; distance takes the
// serial numbers of the given and held dates. Each request also passes through
// the serial number pipeline, which the microcode program waits on.
// The next request can be taken in the cycle after the result is emitted; no
// request is accepted before the last one is through.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver still stalls when a second result is
// ready, the sequencer holds at its emit step until the register frees.
// Reset (rst_n low, synchronous) empties both channels, holds in_stall high
// and loads 01/01/2000.
module gregorian_date_counter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gdc_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output gdc_pkg::out_res_t out_res
);
  import gdc_pkg::*;

  in_req_t   req_r;
  out_res_t  out_r;
  logic      out_valid_r;
  logic      start;
  logic      step_done;
  seq_stat_t stat;
  seq_ctrl_t ctrl;
  out_res_t  res;

  assign in_stall = ctrl.busy || !rst_n;
  assign start    = in_valid && !in_stall;

  // Capture the request on accept
  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= in_req;
    end
  end

  assign stat.kind_set  = (req_r.kind == K_SET);
  assign stat.kind_dist = (req_r.kind == K_DIST);
  assign stat.step_done = step_done;
  assign stat.out_free  = !out_valid_r || !out_stall;

  gdc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  gdc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (start ? in_req : req_r),
    .op        (ctrl.op),
    .step_done (step_done),
    .res       (res)
  );

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> design/gdc_serial_unit.sv
// Three-stage pipeline that turns a date into its serial day number.
// Depends on gdc_pkg for the leap rule and month offset table.
module gdc_serial_unit (
  input  logic        clk,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output logic [21:0] serial
);
  import gdc_pkg::*;

  logic [13:0] p;
  logic [26:0] qp_prod;

  logic [13:0] p_s1_r;
  logic [21:0] p365_s1_r;
  logic [7:0]  qp_s1_r;
  logic [13:0] y_s1_r;
  logic [3:0]  m_s1_r;
  logic [4:0]  d_s1_r;

  logic [21:0] base_s2_r;
  logic        leap_s2_r;
  logic [3:0]  m_s2_r;
  logic [4:0]  d_s2_r;

  logic [21:0] ser_s3_r;

  // Elapsed years and the century count of them
  assign p       = year - 14'd1;
  assign qp_prod = {13'd0, p} * 27'd5243;

  // Stage 1: year terms
  always_ff @(posedge clk) begin
    p_s1_r    <= p;
    p365_s1_r <= {8'd0, p} * 22'd365;
    qp_s1_r   <= qp_prod[26:19];
    y_s1_r    <= year;
    m_s1_r    <= month;
    d_s1_r    <= day;
  end

  // Stage 2: leap day corrections over whole years
  always_ff @(posedge clk) begin
    base_s2_r <= p365_s1_r + ({8'd0, p_s1_r} >> 2) - {14'd0, qp_s1_r} +
                 ({14'd0, qp_s1_r} >> 2);
    leap_s2_r <= leap_of(y_s1_r);
    m_s2_r    <= m_s1_r;
    d_s2_r    <= d_s1_r;
  end

  // Stage 3: add the part of the current year
  always_ff @(posedge clk) begin
    ser_s3_r <= base_s2_r + {13'd0, before_month(m_s2_r)} +
                {21'd0, (m_s2_r > 4'd2) && leap_s2_r} + {17'd0, d_s2_r};
  end

  assign serial = ser_s3_r;

endmodule

>>> design/gdc_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on gdc_pkg for the program and control codes.
module gdc_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gdc_pkg::seq_stat_t  stat,
  output gdc_pkg::seq_ctrl_t  ctrl
);
  import gdc_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            emit;

  assign word = ucode(pc_r);

  // Pick the next step from the condition of the current word
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    emit     = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = PC_START;
      end
    end else begin
      case (word.cond)
        C_NEXT:    pc_nxt = pc_r + 5'd1;
        C_JUMP:    pc_nxt = word.target;
        C_IF_SET:  pc_nxt = stat.kind_set ? word.target : pc_r + 5'd1;
        C_IF_DIST: pc_nxt = stat.kind_dist ? word.target : pc_r + 5'd1;
        C_WHILE:   pc_nxt = !stat.step_done ? word.target : pc_r + 5'd1;
        C_END: begin
          // hold here while the previous result still waits
          if (stat.out_free) begin
            emit     = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default:   pc_nxt = PC_EMIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_START;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl.op   = busy_r ? word.op : OP_NOP;
  assign ctrl.emit = emit;
  assign ctrl.busy = busy_r;

endmodule

>>> design/gdc_datapath.sv
// Datapath: held date, day stepper, validity check, serial and distance regs.
// Depends on gdc_pkg and gdc_serial_unit.
module gdc_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  gdc_pkg::in_req_t       req,
  input  logic [gdc_pkg::OP_W-1:0] op,
  output logic                   step_done,
  output gdc_pkg::out_res_t      res
);
  import gdc_pkg::*;

  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic        leap_r;
  logic [15:0] count_r;
  logic        valid_r;
  logic        ok_r;
  logic [21:0] a_r;
  logic [21:0] ser_r;
  logic [21:0] dist_r;

  logic        fwd;
  logic        at_limit;
  logic [4:0]  len_cur;
  logic [4:0]  len_prev;
  logic [4:0]  day_step;
  logic [3:0]  month_step;
  logic [13:0] year_step;
  logic [4:0]  s_day;
  logic [3:0]  s_month;
  logic [13:0] s_year;
  logic [21:0] serial;
  logic [21:0] diff;

  // Serial operands: the given date on request, else the held date
  always_comb begin
    if (op == OP_SER_GIVEN) begin
      s_day   = req.in_day;
      s_month = req.in_month;
      s_year  = req.in_year;
    end else begin
      s_day   = day_r;
      s_month = month_r;
      s_year  = year_r;
    end
  end

  gdc_serial_unit u_serial (
    .clk    (clk),
    .day    (s_day),
    .month  (s_month),
    .year   (s_year),
    .serial (serial)
  );

  // One day forward or backward; the year only changes across December and
  // January, whose lengths do not depend on the leap flag, so the register lag
  // on leap_r is harmless
  assign fwd      = (req.kind == K_FWD);
  assign len_cur  = month_len(month_r, leap_r);
  assign len_prev = month_len(month_r - 4'd1, leap_r);
  assign at_limit = fwd ? (day_r == 5'd31 && month_r == 4'd12 && year_r == YEAR_MAX)
                        : (day_r == 5'd1 && month_r == 4'd1 && year_r == YEAR_MIN);
  assign step_done = (count_r == 16'd0) || at_limit;

  always_comb begin
    day_step   = day_r;
    month_step = month_r;
    year_step  = year_r;
    if (fwd) begin
      if (day_r < len_cur) begin
        day_step = day_r + 5'd1;
      end else if (month_r == 4'd12) begin
        day_step   = 5'd1;
        month_step = 4'd1;
        year_step  = year_r + 14'd1;
      end else begin
        day_step   = 5'd1;
        month_step = month_r + 4'd1;
      end
    end else begin
      if (day_r > 5'd1) begin
        day_step = day_r - 5'd1;
      end else if (month_r == 4'd1) begin
        day_step   = 5'd31;
        month_step = 4'd12;
        year_step  = year_r - 14'd1;
      end else begin
        day_step   = len_prev;
        month_step = month_r - 4'd1;
      end
    end
  end

  assign diff = (serial >= a_r) ? (serial - a_r) : (a_r - serial);

  // Held date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= 5'd1;
      month_r <= 4'd1;
      year_r  <= YEAR_RST;
    end else if (op == OP_LOAD && valid_r) begin
      day_r   <= req.in_day;
      month_r <= req.in_month;
      year_r  <= req.in_year;
    end else if (op == OP_STEP && !step_done) begin
      day_r   <= day_step;
      month_r <= month_step;
      year_r  <= year_step;
    end
  end

  // Working registers of one request
  always_ff @(posedge clk) begin
    leap_r <= leap_of(year_r);
    if (start) begin
      count_r <= req.step_count;
    end else if (op == OP_STEP && !step_done) begin
      count_r <= count_r - 16'd1;
    end
    case (op)
      OP_CHECK: begin
        valid_r <= date_valid(req.in_day, req.in_month, req.in_year);
        ok_r    <= 1'b0;
        dist_r  <= 22'd0;
      end
      OP_LOAD:   ok_r  <= valid_r;
      OP_SAVE_A: a_r   <= serial;
      OP_CAPT:   ser_r <= serial;
      OP_DIST: begin
        ser_r  <= serial;
        dist_r <= valid_r ? diff : 22'd0;
      end
      default: ;
    endcase
  end

  assign res.cur_day    = day_r;
  assign res.cur_month  = month_r;
  assign res.cur_year   = year_r;
  assign res.serial_day = ser_r;
  assign res.set_ok     = ok_r;
  assign res.distance   = dist_r;

endmodule
